/* src/fsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the FASTA stream parser
// Word kinds, character codes, widths and the word that travels between the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
package fsp_pkg;

	localparam int HEADER_LIMIT = 8192;
	localparam int HIST_BINS    = 256;
	localparam int HL_W         = 14;
	localparam int HIST_AW      = $clog2(HIST_BINS);
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);

	localparam logic [7:0]  CH_HEADER   = 8'h3E;
	localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
	localparam logic [7:0]  CH_PRINT_LO = 8'h20;
	localparam logic [7:0]  CH_PRINT_HI = 8'h7E;
	localparam logic [7:0]  BORDER_RST  = 8'h24;
	localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

	localparam logic [2:0] KIND_SEQ     = 3'd0;
	localparam logic [2:0] KIND_BORDER  = 3'd1;
	localparam logic [2:0] KIND_HDR     = 3'd2;
	localparam logic [2:0] KIND_HDR_END = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_byte;
		logic [31:0] position;
		logic [31:0] record_number;
		logic [31:0] symbol_count;
	} item_t;

endpackage

/* src/fsp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_front: byte classifier
// Accepts input words, tracks header, record and position state, and pushes
// one result word per byte that produces one.
// ----------------------------------------------------------------------------
module fsp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           end_of_input,
	input  logic [7:0]     border_char,
	input  logic           q_full,
	output logic           push,
	output fsp_pkg::item_t push_item
);

	logic                     in_header_q;
	logic [fsp_pkg::HL_W-1:0] header_length_q;
	logic [31:0]              record_total_q;
	logic [31:0]              sequence_length_q;

	logic                     in_header_d;
	logic [fsp_pkg::HL_W-1:0] header_length_d;
	logic [31:0]              record_total_d;
	logic [31:0]              sequence_length_d;
	logic [31:0]              inner;
	logic [31:0]              rec_inc;
	logic [fsp_pkg::HL_W-1:0] hl_inc;
	logic                     accept;
	logic                     has_result;
	logic                     below_limit;
	logic                     printable;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_result;

	always_comb begin
		inner       = (record_total_q != '0) ? record_total_q - 32'd1 : '0;
		rec_inc     = (record_total_q != fsp_pkg::CNT_MAX) ? record_total_q + 32'd1
			: record_total_q;
		hl_inc      = header_length_q + fsp_pkg::HL_W'(1);
		below_limit = header_length_q < fsp_pkg::HL_W'(fsp_pkg::HEADER_LIMIT);
		printable   = (in_byte >= fsp_pkg::CH_PRINT_LO) && (in_byte <= fsp_pkg::CH_PRINT_HI);

		in_header_d       = in_header_q;
		header_length_d   = header_length_q;
		record_total_d    = record_total_q;
		sequence_length_d = sequence_length_q;
		has_result        = 1'b0;
		push_item.kind          = fsp_pkg::KIND_SEQ;
		push_item.out_byte      = in_byte;
		push_item.position      = sequence_length_q;
		push_item.record_number = record_total_q;
		push_item.symbol_count  = '0;

		if (end_of_input) begin
			// summary, then back to the reset state
			has_result              = 1'b1;
			push_item.kind          = fsp_pkg::KIND_END;
			push_item.out_byte      = border_char;
			push_item.symbol_count  = sequence_length_q - inner;
			in_header_d       = 1'b0;
			header_length_d   = '0;
			record_total_d    = '0;
			sequence_length_d = '0;
		end else if (in_byte == fsp_pkg::CH_HEADER) begin
			has_result              = 1'b1;
			in_header_d             = 1'b1;
			record_total_d          = rec_inc;
			header_length_d         = fsp_pkg::HL_W'(1);
			push_item.record_number = rec_inc;
			if (record_total_q != '0) begin
				// border word stands for the '>' as well
				sequence_length_d      = sequence_length_q + 32'd1;
				push_item.kind         = fsp_pkg::KIND_BORDER;
				push_item.out_byte     = border_char;
			end else begin
				push_item.kind         = fsp_pkg::KIND_HDR;
				push_item.symbol_count = 32'd1;
			end
		end else if (in_header_q) begin
			if (in_byte == fsp_pkg::CH_NEWLINE) begin
				has_result             = 1'b1;
				in_header_d            = 1'b0;
				push_item.kind         = fsp_pkg::KIND_HDR_END;
				push_item.symbol_count = 32'(header_length_q);
			end else if (below_limit && printable) begin
				has_result             = 1'b1;
				header_length_d        = hl_inc;
				push_item.kind         = fsp_pkg::KIND_HDR;
				push_item.symbol_count = 32'(hl_inc);
			end
		end else if (in_byte != fsp_pkg::CH_NEWLINE) begin
			// sequence byte: count is filled in by the back end
			has_result        = 1'b1;
			sequence_length_d = sequence_length_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q       <= 1'b0;
			header_length_q   <= '0;
			record_total_q    <= '0;
			sequence_length_q <= '0;
		end else if (accept) begin
			in_header_q       <= in_header_d;
			header_length_q   <= header_length_d;
			record_total_q    <= record_total_d;
			sequence_length_q <= sequence_length_d;
		end
	end

endmodule

/* src/fsp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_queue: result word queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output fsp_pkg::item_t q_item
);

	fsp_pkg::item_t             entry_q [fsp_pkg::Q_DEPTH];
	logic [fsp_pkg::Q_AW-1:0]   wr_ptr_q;
	logic [fsp_pkg::Q_AW-1:0]   rd_ptr_q;
	logic [fsp_pkg::Q_AW:0]     count_q;

	assign full    = count_q == (fsp_pkg::Q_AW+1)'(fsp_pkg::Q_DEPTH);
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fsp_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fsp_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (fsp_pkg::Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (fsp_pkg::Q_AW+1)'(1);
			end
		end
	end

endmodule

/* src/fsp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_back: histogram update and output register
// Reads the histogram bin of each sequence byte, saturates and writes the
// count back, and presents result words on the output channel.
// ----------------------------------------------------------------------------
module fsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  fsp_pkg::item_t q_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output fsp_pkg::item_t out_item
);

	logic [31:0]                  hist_mem [fsp_pkg::HIST_BINS];
	logic [fsp_pkg::HIST_BINS-1:0] hist_vld_q;
	logic [31:0]                  rd_q;
	logic [fsp_pkg::HIST_AW-1:0]  rd_addr;

	fsp_pkg::item_t               item_s1;
	logic                         vld_s1;
	logic                         fwd_vld_q;
	logic [fsp_pkg::HIST_AW-1:0]  fwd_addr_q;
	logic [31:0]                  fwd_cnt_q;
	logic                         out_vld_q;
	fsp_pkg::item_t               out_q;

	logic                         adv;
	logic                         is_seq;
	logic [fsp_pkg::HIST_AW-1:0]  addr_s1;
	logic [31:0]                  old_cnt;
	logic [31:0]                  new_cnt;
	fsp_pkg::item_t               done_item;

	assign adv       = vld_s1 && (!out_vld_q || out_ready);
	assign pop       = q_valid && (!vld_s1 || adv);
	assign out_valid = out_vld_q;
	assign out_item  = out_q;
	assign addr_s1   = item_s1.out_byte[fsp_pkg::HIST_AW-1:0];
	assign is_seq    = item_s1.kind == fsp_pkg::KIND_SEQ;
	assign rd_addr   = pop ? q_item.out_byte[fsp_pkg::HIST_AW-1:0] : addr_s1;

	always_comb begin
		// forward the last written count over the stale read
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			old_cnt = fwd_cnt_q;
		end else if (hist_vld_q[addr_s1]) begin
			old_cnt = rd_q;
		end else begin
			old_cnt = '0;
		end
		new_cnt   = (old_cnt != fsp_pkg::CNT_MAX) ? old_cnt + 32'd1 : old_cnt;
		done_item = item_s1;
		if (is_seq) begin
			done_item.symbol_count = new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= hist_mem[rd_addr];
		if (adv && is_seq) begin
			hist_mem[addr_s1] <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_item;
		end
		if (adv) begin
			out_q <= done_item;
		end
		if (adv && is_seq) begin
			fwd_addr_q <= addr_s1;
			fwd_cnt_q  <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			fwd_vld_q  <= 1'b0;
			hist_vld_q <= '0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (adv && is_seq) begin
				fwd_vld_q           <= 1'b1;
				hist_vld_q[addr_s1] <= 1'b1;
			end else if (adv && (item_s1.kind == fsp_pkg::KIND_END)) begin
				fwd_vld_q  <= 1'b0;
				hist_vld_q <= '0;
			end
		end
	end

endmodule

/* src/fasta_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_stream_parser: byte-serial FASTA parser
// Sorts a FASTA byte stream into header, border and sequence words and keeps
// a saturating 256-bin histogram of the sequence bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one byte word per cycle while
//   in_ready is high; end_of_input closes the file with the summary word.
//   Output channel (out_valid/out_ready) carries at most one result word per
//   input word; newlines outside headers and dropped header bytes give none.
//   Throughput: one word per cycle with out_ready high, set by the single
//   read and write port of the histogram memory with last-write forwarding.
//   Path: the word is written into the queue at the accepting edge, then
//   moves through the histogram read stage and the output register to
//   out_valid.
//   Receiver stall: the output register holds its word; the four-word queue
//   keeps accepting until it fills, then in_ready drops.
//   Reset: all counters clear, border_char returns to '$', and every
//   histogram bin reads zero at once through per-bin valid flops, so no
//   clearing pass is needed. The end-of-input word does the same clear
//   while border_char keeps its value.
//   Config: cfg_we writes border_char; write only while the block is idle.
// ----------------------------------------------------------------------------
module fasta_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [31:0] position,
	output logic [31:0] record_number,
	output logic [31:0] symbol_count
);

	logic           [7:0] border_char_q;
	logic                 q_full;
	logic                 push;
	logic                 pop;
	logic                 q_valid;
	fsp_pkg::item_t       push_item;
	fsp_pkg::item_t       q_item;
	fsp_pkg::item_t       out_item;

	// border marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_char_q <= fsp_pkg::BORDER_RST;
		end else if (cfg_we) begin
			border_char_q <= cfg_data;
		end
	end

	// classify bytes and update the scalar parser state
	fsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_input(end_of_input),
		.border_char (border_char_q),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// decouple the classifier from histogram and output stalls
	fsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	// histogram read-modify-write and output register
	fsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	assign kind          = out_item.kind;
	assign out_byte      = out_item.out_byte;
	assign position      = out_item.position;
	assign record_number = out_item.record_number;
	assign symbol_count  = out_item.symbol_count;

endmodule

/* src/fsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_checker: port-level checks of the FASTA stream parser
// Watches the output channel for handshake and word-content slips.
// ----------------------------------------------------------------------------
module fsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [7:0]  out_byte,
	input logic [31:0] position,
	input logic [31:0] record_number,
	input logic [31:0] symbol_count
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
			&& $stable(position) && $stable(record_number) && $stable(symbol_count))
		else $error("stalled output word changed");

	a_seq_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsp_pkg::KIND_SEQ) |-> symbol_count != 32'd0)
		else $error("sequence byte with zero histogram count");

	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsp_pkg::KIND_BORDER) |->
			(symbol_count == 32'd0) && (record_number >= 32'd2))
		else $error("border word with bad count or record number");

	a_hdr_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsp_pkg::KIND_HDR_END) |->
			(out_byte == fsp_pkg::CH_NEWLINE) && (record_number != 32'd0))
		else $error("header end word malformed");

endmodule

bind fasta_stream_parser fsp_checker u_fsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.out_byte     (out_byte),
	.position     (position),
	.record_number(record_number),
	.symbol_count (symbol_count)
);
